// ----- hdl/fbpc_pkg.sv -----
// Shared types and codes for the frustum box and point cull block.
// Used by every module of the block; depends on nothing.
package fbpc_pkg;

    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_POINT = 2'd1,
        MODE_BOX   = 2'd2,
        MODE_NONE  = 2'd3
    } fbpc_mode_t;

    typedef struct packed {
        logic              valid;
        fbpc_mode_t        mode;
        logic [3:0]        entry_index;
        logic [31:0]       entry_value;
        logic [2:0][31:0]  pmin;
        logic [2:0][31:0]  pmax;
        logic [2:0]        max_gt;
        logic [2:0]        max_lt;
        logic              visible;
    } fbpc_word_t;

    typedef struct packed {
        logic valid;
        logic visible;
    } fbpc_result_t;

endpackage

// ----- hdl/frustum_box_and_point_cull_top.sv -----
// Top level of the frustum box and point cull block: input register, six plane cells
// and the result skid stage. Depends on fbpc_pkg, fbpc_cell and fbpc_out_skid.
//
//  channel  | ports               | word
//  ---------+---------------------+--------------------------------------------
//  input    | s_valid / s_ready   | mode, entry index and value, min and max xyz
//  result   | m_valid / m_ready   | visible, one per point or box test
//
// One word is accepted every cycle while the skid stage is not full; a test word's result
// goes through one input register, two stages in each of six plane cells, one output register.
// Loads travel down the chain and update each plane cell as they pass it.
// Reset clears the stored matrix to zero in every cell.
// The chain stalls only when the skid stage is full.
module frustum_box_and_point_cull_top #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [3:0]  s_entry_index,
    input  logic [31:0] s_entry_value,
    input  logic [31:0] s_min_x,
    input  logic [31:0] s_min_y,
    input  logic [31:0] s_min_z,
    input  logic [31:0] s_max_x,
    input  logic [31:0] s_max_y,
    input  logic [31:0] s_max_z,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_visible
);

    localparam int         CW        = COORD_WIDTH;
    localparam logic [5:0] SUB_MASK  = 6'b100110;
    localparam logic [5:0] HAS_MASK  = 6'b101111;

    logic                   en;
    fbpc_pkg::fbpc_word_t   word_in_next;
    fbpc_pkg::fbpc_word_t   word_in_reg;
    fbpc_pkg::fbpc_word_t   chain [7];
    fbpc_pkg::fbpc_result_t res;

    assign s_ready = en;

    always_comb begin
        word_in_next.valid       = s_valid;
        word_in_next.mode        = fbpc_pkg::fbpc_mode_t'(s_mode);
        word_in_next.entry_index = s_entry_index;
        word_in_next.entry_value = s_entry_value;
        word_in_next.pmin        = {s_min_z, s_min_y, s_min_x};
        word_in_next.pmax        = {s_max_z, s_max_y, s_max_x};
        word_in_next.max_gt[0]   = $signed(s_max_x[CW-1:0]) > $signed(s_min_x[CW-1:0]);
        word_in_next.max_gt[1]   = $signed(s_max_y[CW-1:0]) > $signed(s_min_y[CW-1:0]);
        word_in_next.max_gt[2]   = $signed(s_max_z[CW-1:0]) > $signed(s_min_z[CW-1:0]);
        word_in_next.max_lt[0]   = $signed(s_max_x[CW-1:0]) < $signed(s_min_x[CW-1:0]);
        word_in_next.max_lt[1]   = $signed(s_max_y[CW-1:0]) < $signed(s_min_y[CW-1:0]);
        word_in_next.max_lt[2]   = $signed(s_max_z[CW-1:0]) < $signed(s_min_z[CW-1:0]);
        word_in_next.visible     = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_in_reg <= '0;
        end else if (en) begin
            word_in_reg <= word_in_next;
        end
    end

    assign chain[0] = word_in_reg;

    for (genvar p = 0; p < 6; p++) begin : g_cell
        fbpc_cell #(
            .CW     (CW),
            .FRAC   (FRAC_BITS),
            .COL    (p / 2),
            .SUB    (SUB_MASK[p]),
            .HAS_C3 (HAS_MASK[p])
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .word_in  (chain[p]),
            .word_out (chain[p+1])
        );
    end

    assign res.valid   = chain[6].valid &&
                         ((chain[6].mode == fbpc_pkg::MODE_POINT) ||
                          (chain[6].mode == fbpc_pkg::MODE_BOX));
    assign res.visible = chain[6].visible;

    fbpc_out_skid u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .res_in      (res),
        .chain_ready (en),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_visible   (m_visible)
    );

endmodule

// ----- hdl/fbpc_cell.sv -----
// One plane cell of the culling chain: holds its plane, multiplies, then sums and tests.
// Depends on fbpc_pkg.
module fbpc_cell #(
    parameter int          CW      = 32,
    parameter int          FRAC    = 16,
    parameter int unsigned COL     = 0,
    parameter bit          SUB     = 1'b0,
    parameter bit          HAS_C3  = 1'b1
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  fbpc_pkg::fbpc_word_t word_in,
    output fbpc_pkg::fbpc_word_t word_out
);

    localparam int AW     = CW + 1;
    localparam int PROD_W = 2 * CW + 1;
    localparam int OFF_W  = CW + 1 + FRAC;
    localparam int SUM_W  = ((PROD_W > OFF_W) ? PROD_W : OFF_W) + 2;

    logic signed [CW-1:0]     ent3_reg [4];
    logic signed [CW-1:0]     entk_reg [4];
    logic signed [AW-1:0]     comp_reg [4];

    fbpc_pkg::fbpc_word_t     word_a_reg;
    fbpc_pkg::fbpc_word_t     word_b_reg;
    fbpc_pkg::fbpc_word_t     word_b_next;
    logic signed [PROD_W-1:0] prod_reg  [3];
    logic signed [PROD_W-1:0] prod_next [3];
    logic signed [AW-1:0]     off_reg;

    logic                     ld;
    logic [1:0]               ld_row;
    logic [1:0]               ld_col;
    logic signed [CW-1:0]     ld_val;
    logic signed [SUM_W-1:0]  sum;
    logic                     fail;

    assign ld     = word_in.valid && (word_in.mode == fbpc_pkg::MODE_LOAD);
    assign ld_row = word_in.entry_index[3:2];
    assign ld_col = word_in.entry_index[1:0];
    assign ld_val = $signed(word_in.entry_value[CW-1:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < 4; r++) begin
                ent3_reg[r] <= '0;
                entk_reg[r] <= '0;
                comp_reg[r] <= '0;
            end
        end else if (en && ld) begin
            if (ld_col == 2'd3) begin
                ent3_reg[ld_row] <= ld_val;
                if (HAS_C3) begin
                    comp_reg[ld_row] <= SUB ? (AW'(ld_val) - AW'(entk_reg[ld_row]))
                                            : (AW'(ld_val) + AW'(entk_reg[ld_row]));
                end
            end else if (ld_col == 2'(COL)) begin
                entk_reg[ld_row] <= ld_val;
                if (HAS_C3) begin
                    comp_reg[ld_row] <= SUB ? (AW'(ent3_reg[ld_row]) - AW'(ld_val))
                                            : (AW'(ent3_reg[ld_row]) + AW'(ld_val));
                end else begin
                    comp_reg[ld_row] <= AW'(ld_val);
                end
            end
        end
    end

    // For a box test the larger of the two corner products is taken by choosing the coordinate
    // from the sign of the plane component and the order of min and max; points use min.
    always_comb begin
        logic signed [AW-1:0] a;
        logic signed [CW-1:0] coord;
        logic                 a_pos;
        logic                 use_max;
        for (int k = 0; k < 3; k++) begin
            a       = comp_reg[k];
            a_pos   = !a[AW-1] && (a != '0);
            use_max = (word_in.mode == fbpc_pkg::MODE_BOX) &&
                      ((a_pos && word_in.max_gt[k]) || (a[AW-1] && word_in.max_lt[k]));
            coord   = use_max ? $signed(word_in.pmax[k][CW-1:0])
                              : $signed(word_in.pmin[k][CW-1:0]);
            prod_next[k] = PROD_W'(a) * PROD_W'(coord);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_a_reg <= '0;
            word_b_reg <= '0;
        end else if (en) begin
            word_a_reg <= word_in;
            word_b_reg <= word_b_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                prod_reg[k] <= prod_next[k];
            end
            off_reg <= comp_reg[3];
        end
    end

    always_comb begin
        sum = SUM_W'(prod_reg[0]) + SUM_W'(prod_reg[1]) + SUM_W'(prod_reg[2])
            + (SUM_W'(off_reg) <<< FRAC);
        if (word_a_reg.mode == fbpc_pkg::MODE_POINT) begin
            fail = sum[SUM_W-1];
        end else begin
            fail = sum[SUM_W-1] || (sum == '0);
        end
        word_b_next = word_a_reg;
        if (word_a_reg.valid && fail &&
            ((word_a_reg.mode == fbpc_pkg::MODE_POINT) ||
             (word_a_reg.mode == fbpc_pkg::MODE_BOX))) begin
            word_b_next.visible = 1'b0;
        end
    end

    assign word_out = word_b_reg;

endmodule

// ----- hdl/fbpc_out_skid.sv -----
// Output register with a skid stage for the result channel.
// Depends on fbpc_pkg.
module fbpc_out_skid (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  fbpc_pkg::fbpc_result_t res_in,
    output logic                   chain_ready,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_visible
);

    logic out_valid_reg;
    logic out_visible_reg;
    logic skid_valid_reg;
    logic skid_visible_reg;
    logic in_fire;

    assign chain_ready = !skid_valid_reg;
    assign in_fire     = res_in.valid && !skid_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_valid_reg && !m_ready) begin
            if (in_fire) begin
                skid_valid_reg <= 1'b1;
            end
        end else if (skid_valid_reg) begin
            out_valid_reg  <= 1'b1;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= in_fire;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_valid_reg && !m_ready) begin
            if (in_fire) begin
                skid_visible_reg <= res_in.visible;
            end
        end else if (skid_valid_reg) begin
            out_visible_reg <= skid_visible_reg;
        end else if (in_fire) begin
            out_visible_reg <= res_in.visible;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_visible = out_visible_reg;

endmodule

// ----- test/frustum_box_and_point_cull_top_test.sv -----
// Self-checking testbench for frustum_box_and_point_cull_top: a directed table, then random
// loads, point tests and box tests; each result is checked against a model of the frustum
// cull or a fixed expected value. Depends on fbpc_pkg and the block's RTL only.
module frustum_box_and_point_cull_top_test;

    localparam int COORD_WIDTH  = 32;
    localparam int FRAC_BITS    = 16;
    localparam int RANDOM_WORDS = 950;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 40;

    localparam logic [31:0] ONE     = 32'h0001_0000;
    localparam logic [31:0] TWO     = 32'h0002_0000;
    localparam logic [31:0] HALF    = 32'h0000_8000;
    localparam logic [31:0] NEG_ONE = 32'hFFFF_0000;
    localparam logic [31:0] NEG_TWO = 32'hFFFE_0000;
    localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] NEG_MAX = 32'h8000_0000;

    typedef enum int {
        PL_LEFT, PL_RIGHT, PL_TOP, PL_BOTTOM, PL_NEAR, PL_FAR
    } plane_t;

    typedef struct packed {
        fbpc_pkg::fbpc_mode_t mode;
        logic [3:0]           entry_index;
        logic [31:0]          entry_value;
        logic [2:0][31:0]     lo_corner;
        logic [2:0][31:0]     hi_corner;
    } cull_word_t;

    typedef struct packed {
        cull_word_t w;
        logic       typed;
        logic       typed_visible;
    } cull_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_mode;
    logic [3:0]  s_entry_index;
    logic [31:0] s_entry_value;
    logic [31:0] s_min_x;
    logic [31:0] s_min_y;
    logic [31:0] s_min_z;
    logic [31:0] s_max_x;
    logic [31:0] s_max_y;
    logic [31:0] s_max_z;
    logic        m_valid;
    logic        m_ready;
    logic        m_visible;

    logic        in_fire;
    logic        out_fire;
    logic        out_visible;
    logic        want_visible;
    int          error_count;
    int          idle_cycles;
    int          ready_stall;

    logic [31:0] cull_matrix [16];
    logic        visible_expected [$];
    cull_row_t   directed_rows [$];

    frustum_box_and_point_cull_top #(
        .COORD_WIDTH(COORD_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_entry_index(s_entry_index),
        .s_entry_value(s_entry_value),
        .s_min_x      (s_min_x),
        .s_min_y      (s_min_y),
        .s_min_z      (s_min_z),
        .s_max_x      (s_max_x),
        .s_max_y      (s_max_y),
        .s_max_z      (s_max_z),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_visible    (m_visible)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic logic predict_visible(input cull_word_t w);
        longint              e0, e1, e2, e3;
        longint              comp [4];
        logic signed [127:0] plane_dist, coef, c_lo, c_hi, p_lo, p_hi;
        logic                vis;
        vis = 1'b1;
        for (int p = PL_LEFT; p <= PL_FAR; p++) begin
            for (int r = 0; r < 4; r++) begin
                e0 = 64'($signed(cull_matrix[r * 4]));
                e1 = 64'($signed(cull_matrix[r * 4 + 1]));
                e2 = 64'($signed(cull_matrix[r * 4 + 2]));
                e3 = 64'($signed(cull_matrix[r * 4 + 3]));
                case (p)
                    PL_LEFT:   comp[r] = e3 + e0;
                    PL_RIGHT:  comp[r] = e3 - e0;
                    PL_TOP:    comp[r] = e3 - e1;
                    PL_BOTTOM: comp[r] = e3 + e1;
                    PL_NEAR:   comp[r] = e2;
                    default:   comp[r] = e3 - e2;
                endcase
            end
            plane_dist = 128'(comp[3]);
            plane_dist = plane_dist <<< FRAC_BITS;
            for (int k = 0; k < 3; k++) begin
                coef = 128'(comp[k]);
                c_lo = 128'($signed(w.lo_corner[k]));
                c_hi = 128'($signed(w.hi_corner[k]));
                p_lo = coef * c_lo;
                p_hi = coef * c_hi;
                if (w.mode == fbpc_pkg::MODE_POINT) begin
                    plane_dist = plane_dist + p_lo;
                end else begin
                    plane_dist = plane_dist + ((p_lo > p_hi) ? p_lo : p_hi);
                end
            end
            if (w.mode == fbpc_pkg::MODE_POINT ? (plane_dist < 0) : (plane_dist <= 0)) begin
                vis = 1'b0;
            end
        end
        return vis;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] rand_coord();
        if ($urandom_range(0, 9) < 7) begin
            return $urandom_range(0, 32'h0003_0000) - 32'h0001_8000;
        end
        return $urandom();
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    task automatic add_row(input fbpc_pkg::fbpc_mode_t m, input logic [3:0] idx,
                           input logic [31:0] val,
                           input logic [31:0] lx, input logic [31:0] ly, input logic [31:0] lz,
                           input logic [31:0] hx, input logic [31:0] hy, input logic [31:0] hz,
                           input logic typed, input logic typed_visible);
        cull_row_t row;
        row.w.mode          = m;
        row.w.entry_index   = idx;
        row.w.entry_value   = val;
        row.w.lo_corner     = {lz, ly, lx};
        row.w.hi_corner     = {hz, hy, hx};
        row.typed           = typed;
        row.typed_visible   = typed_visible;
        directed_rows.push_back(row);
    endtask

    task automatic send_word(input cull_word_t w, input logic typed, input logic typed_visible,
                             input int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_mode        <= w.mode;
        s_entry_index <= w.entry_index;
        s_entry_value <= w.entry_value;
        s_min_x       <= w.lo_corner[0];
        s_min_y       <= w.lo_corner[1];
        s_min_z       <= w.lo_corner[2];
        s_max_x       <= w.hi_corner[0];
        s_max_y       <= w.hi_corner[1];
        s_max_z       <= w.hi_corner[2];
        @(posedge aclk);
        while (!in_fire) @(posedge aclk);
        if (w.mode == fbpc_pkg::MODE_LOAD) begin
            cull_matrix[w.entry_index] = w.entry_value;
        end else if (w.mode == fbpc_pkg::MODE_POINT || w.mode == fbpc_pkg::MODE_BOX) begin
            visible_expected.push_back(typed ? typed_visible : predict_visible(w));
        end
    endtask

    // Handshakes and the result are sampled mid-cycle, where nothing is changing.
    always @(negedge aclk) begin
        in_fire     = aresetn && s_valid && s_ready;
        out_fire    = aresetn && m_valid && m_ready;
        out_visible = m_visible;
    end

    always @(posedge aclk) begin
        if (out_fire) begin
            if (visible_expected.size() == 0) begin
                report_mismatch("result word with nothing expected");
            end else begin
                want_visible = visible_expected.pop_front();
                if (out_visible !== want_visible) begin
                    report_mismatch($sformatf("visible %b, expected %b",
                                              out_visible, want_visible));
                end
            end
        end
    end

    initial begin
        m_ready = 1'b0;
        wait (aresetn);
        forever begin
            m_ready <= 1'b1;
            repeat ($urandom_range(0, 9) == 0 ? 200 : $urandom_range(1, 12)) @(posedge aclk);
            ready_stall = pick_gap();
            if (ready_stall > 0) begin
                m_ready <= 1'b0;
                repeat (ready_stall) @(posedge aclk);
            end
        end
    end

    initial begin
        idle_cycles = 0;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (in_fire || out_fire) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("frustum_box_and_point_cull_top_test: done, errors");
                $finish;
            end
        end
    end

    initial begin
        cull_word_t w;
        int         accepted;
        int         gap;
        int         r;

        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_mode        = fbpc_pkg::MODE_LOAD;
        s_entry_index = '0;
        s_entry_value = '0;
        s_min_x       = '0;
        s_min_y       = '0;
        s_min_z       = '0;
        s_max_x       = '0;
        s_max_y       = '0;
        s_max_z       = '0;
        error_count   = 0;
        for (int i = 0; i < 16; i++) cull_matrix[i] = '0;

        // With the store cleared every plane is zero: a point sits on all of them,
        // a box touches them and is culled.
        add_row(fbpc_pkg::MODE_POINT, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1);
        add_row(fbpc_pkg::MODE_BOX, 0, 0, NEG_MAX, NEG_MAX, NEG_MAX, POS_MAX, POS_MAX, POS_MAX,
                1, 0);
        add_row(fbpc_pkg::MODE_NONE, 4'hF, POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX,
                POS_MAX, 0, 0);
        add_row(fbpc_pkg::MODE_LOAD, 0, ONE, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(fbpc_pkg::MODE_LOAD, 5, ONE, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(fbpc_pkg::MODE_LOAD, 10, ONE, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(fbpc_pkg::MODE_LOAD, 15, ONE, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(fbpc_pkg::MODE_POINT, 0, 0, 0, 0, HALF, 0, 0, 0, 0, 0);
        add_row(fbpc_pkg::MODE_POINT, 0, 0, TWO, 0, HALF, 0, 0, 0, 0, 0);
        add_row(fbpc_pkg::MODE_POINT, 0, 0, ONE, 0, 0, 0, 0, 0, 0, 0);
        add_row(fbpc_pkg::MODE_BOX, 0, 0, NEG_TWO, NEG_TWO, NEG_TWO, TWO, TWO, TWO, 0, 0);
        add_row(fbpc_pkg::MODE_BOX, 0, 0, ONE, 0, HALF, ONE, 0, HALF, 0, 0);
        add_row(fbpc_pkg::MODE_BOX, 0, 0, TWO, 0, HALF, TWO, ONE, ONE, 0, 0);
        add_row(fbpc_pkg::MODE_BOX, 0, 0, ONE, ONE, ONE, NEG_ONE, NEG_ONE, 0, 0, 0);
        add_row(fbpc_pkg::MODE_POINT, 0, 0, NEG_MAX, NEG_MAX, NEG_MAX, 0, 0, 0, 0, 0);
        add_row(fbpc_pkg::MODE_BOX, 0, 0, NEG_MAX, NEG_MAX, NEG_MAX, POS_MAX, POS_MAX, POS_MAX,
                0, 0);
        add_row(fbpc_pkg::MODE_LOAD, 3, POS_MAX, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(fbpc_pkg::MODE_LOAD, 12, NEG_MAX, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(fbpc_pkg::MODE_POINT, 0, 0, POS_MAX, POS_MAX, POS_MAX, 0, 0, 0, 0, 0);
        add_row(fbpc_pkg::MODE_POINT, 0, 0, NEG_MAX, 0, POS_MAX, 0, 0, 0, 0, 0);
        add_row(fbpc_pkg::MODE_BOX, 0, 0, POS_MAX, POS_MAX, POS_MAX, NEG_MAX, NEG_MAX, NEG_MAX,
                0, 0);
        add_row(fbpc_pkg::MODE_BOX, 0, 0, NEG_ONE, NEG_ONE, 0, ONE, ONE, ONE, 0, 0);
        add_row(fbpc_pkg::MODE_NONE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            send_word(directed_rows[i].w, directed_rows[i].typed,
                      directed_rows[i].typed_visible, pick_gap());
        end

        accepted = 0;
        while (accepted < RANDOM_WORDS) begin
            r = $urandom_range(0, 99);
            if (r < 15) begin
                w.mode = fbpc_pkg::MODE_LOAD;
            end else if (r < 50) begin
                w.mode = fbpc_pkg::MODE_POINT;
            end else if (r < 96) begin
                w.mode = fbpc_pkg::MODE_BOX;
            end else begin
                w.mode = fbpc_pkg::MODE_NONE;
            end
            w.entry_index = 4'($urandom_range(0, 15));
            if ($urandom_range(0, 99) < 15) begin
                w.entry_value = $urandom();
            end else begin
                // Keep the matrix close to a unit frustum so both outcomes stay common.
                w.entry_value = ((w.entry_index[3:2] == w.entry_index[1:0]) ? ONE : 32'h0)
                                + $urandom_range(0, 32'h6000) - 32'h3000;
            end
            for (int k = 0; k < 3; k++) begin
                w.lo_corner[k] = rand_coord();
                w.hi_corner[k] = rand_coord();
                if ($urandom_range(0, 3) != 0 &&
                    $signed(w.lo_corner[k]) > $signed(w.hi_corner[k])) begin
                    {w.lo_corner[k], w.hi_corner[k]} = {w.hi_corner[k], w.lo_corner[k]};
                end
            end
            gap = ((accepted / 100) % 3 == 1) ? 0 : pick_gap();
            send_word(w, 1'b0, 1'b0, gap);
            if (w.mode != fbpc_pkg::MODE_NONE) accepted++;
        end
        s_valid <= 1'b0;

        while (visible_expected.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("frustum_box_and_point_cull_top_test: done, clean");
        end else begin
            $display("frustum_box_and_point_cull_top_test: done, errors");
        end
        $finish;
    end

endmodule
